[rtl/split_fir_convolver_with_tone_filters_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the split FIR convolver
// Clocked, reset-qualified immediate and next-cycle implications.
// ----------------------------------------------------------------------------
`ifndef SPLIT_FIR_CONVOLVER_WITH_TONE_FILTERS_TOP_MACROS_SVH
`define SPLIT_FIR_CONVOLVER_WITH_TONE_FILTERS_TOP_MACROS_SVH

// same-cycle implication
`define SFC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sfc_pkg.sv]
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared types, codes and saturation helpers of the split FIR convolver.
// ----------------------------------------------------------------------------
`default_nettype none

package sfc_pkg;

  localparam int unsigned IDX_W = 15;

  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_HEAD_WR = 2'd1,
    OP_TAIL_WR = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_MIX  = 2'd0,
    CFG_LPC  = 2'd1,
    CFG_HPC  = 2'd2,
    CFG_TLEN = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    STEP_NONE,
    STEP_WET,
    STEP_LP_MUL,
    STEP_LP_UPD,
    STEP_HP_MUL,
    STEP_HP_UPD,
    STEP_DRY_MUL,
    STEP_WET_MUL
  } step_e;

  typedef enum logic [3:0] {
    S_SWEEP,
    S_IDLE,
    S_HEAD,
    S_TAIL,
    S_DRAIN,
    S_WET,
    S_LP_MUL,
    S_LP_UPD,
    S_HP_MUL,
    S_HP_UPD,
    S_DRY_MUL,
    S_WET_MUL,
    S_OUT
  } ctl_state_e;

  typedef struct packed {
    logic             sweep;
    logic             sweep_taps;
    logic             smp_wr;
    logic             head_tap_wr;
    logic             tail_tap_wr;
    logic             clr_state;
    logic             mac_rd;
    logic             mac_tail;
    logic             adv_pos;
    step_e            step;
    logic             out_ld;
    logic [IDX_W-1:0] idx;
  } sfc_cmd_t;

  typedef struct packed {
    logic             mac_busy;
    logic             out_hold;
    logic             tail_on;
    logic [IDX_W-1:0] tail_len;
  } sfc_sts_t;

  localparam logic [16:0] MIX_RST  = 17'd26214;
  localparam logic [15:0] LPC_RST  = 16'd58831;
  localparam logic [15:0] HPC_RST  = 16'd65164;
  localparam logic [16:0] MIX_ONE  = 17'h10000;

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;
  localparam logic signed [63:0] S24_MAX = 64'sd8388607;
  localparam logic signed [63:0] S24_MIN = -64'sd8388608;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) r = 32'sh7fffffff;
    else if (v < S32_MIN) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
    logic signed [23:0] r;
    if (v > S24_MAX) r = 24'sh7fffff;
    else if (v < S24_MIN) r = 24'sh800000;
    else r = v[23:0];
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/sfc_ram.sv]
// ----------------------------------------------------------------------------
// sfc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sfc_ram #(
  parameter int unsigned W = 24,
  parameter int unsigned D = 128
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [$clog2(D)-1:0] waddr_i,
  input  wire logic [W-1:0]         wdata_i,
  input  wire logic [$clog2(D)-1:0] raddr_i,
  output logic      [W-1:0]         rdata_o
);

  logic [W-1:0] mem_q [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/sfc_dpath.sv]
// ----------------------------------------------------------------------------
// sfc_dpath
// Rings, tap memories, shared MAC, tone filters, mixer and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sfc_dpath import sfc_pkg::*; #(
  parameter int unsigned HEAD_TAPS = 128,
  parameter int unsigned TAIL_TAPS = 2048
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire sfc_cmd_t           cmd_i,
  output sfc_sts_t                sts_o,
  input  wire logic [10:0]        tap_index_i,
  input  wire logic signed [23:0] sample_in_i,
  input  wire logic signed [17:0] tap_value_i,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [16:0]        cfg_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [23:0]      sample_out_o
);

  localparam int unsigned HW    = $clog2(HEAD_TAPS);
  localparam int unsigned TW    = $clog2(TAIL_TAPS);
  localparam int unsigned ACC_W = 43 + $clog2(HEAD_TAPS + TAIL_TAPS);

  logic [16:0] mix_q;
  logic [15:0] lpc_q, hpc_q;
  logic [11:0] tlen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mix_q  <= MIX_RST;
      lpc_q  <= LPC_RST;
      hpc_q  <= HPC_RST;
      tlen_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MIX:  mix_q  <= cfg_data_i;
        CFG_LPC:  lpc_q  <= cfg_data_i[15:0];
        CFG_HPC:  hpc_q  <= cfg_data_i[15:0];
        CFG_TLEN: tlen_q <= cfg_data_i[11:0];
        default:  ;
      endcase
    end
  end

  logic [IDX_W-1:0] tlen_ext, tlen_eff;
  logic [16:0]      mix_eff;
  logic             tail_on;

  assign tlen_ext = IDX_W'(tlen_q);
  assign tlen_eff = (tlen_ext > IDX_W'(TAIL_TAPS)) ? IDX_W'(TAIL_TAPS) : tlen_ext;
  assign tail_on  = (tlen_eff != '0);
  assign mix_eff  = mix_q[16] ? MIX_ONE : mix_q;

  logic [HW-1:0] hpos_q;
  logic [TW-1:0] tpos_q;

  logic              hh_we, ht_we, th_we, tt_we;
  logic [HW-1:0]     hh_wa, ht_wa, hh_ra, ht_ra;
  logic [TW-1:0]     th_wa, tt_wa, th_ra, tt_ra;
  logic [23:0]       hh_wd, th_wd, hh_rd, th_rd;
  logic [17:0]       ht_wd, tt_wd, ht_rd, tt_rd;
  logic              in_head;
  logic              in_tail;

  assign in_head = (cmd_i.idx < IDX_W'(HEAD_TAPS));
  assign in_tail = (cmd_i.idx < IDX_W'(TAIL_TAPS));

  assign hh_we = (cmd_i.sweep && in_head) || cmd_i.smp_wr;
  assign hh_wa = cmd_i.sweep ? cmd_i.idx[HW-1:0] : hpos_q;
  assign hh_wd = cmd_i.sweep ? '0 : sample_in_i;
  assign th_we = (cmd_i.sweep && in_tail) || (cmd_i.smp_wr && tail_on);
  assign th_wa = cmd_i.sweep ? cmd_i.idx[TW-1:0] : tpos_q;
  assign th_wd = cmd_i.sweep ? '0 : sample_in_i;

  assign ht_we = (cmd_i.sweep && cmd_i.sweep_taps && in_head) || cmd_i.head_tap_wr;
  assign ht_wa = cmd_i.sweep ? cmd_i.idx[HW-1:0] : tap_index_i[HW-1:0];
  assign ht_wd = cmd_i.sweep ? '0 : tap_value_i;
  assign tt_we = (cmd_i.sweep && cmd_i.sweep_taps && in_tail) || cmd_i.tail_tap_wr;
  assign tt_wa = cmd_i.sweep ? cmd_i.idx[TW-1:0] : TW'(tap_index_i);
  assign tt_wd = cmd_i.sweep ? '0 : tap_value_i;

  assign hh_ra = hpos_q - cmd_i.idx[HW-1:0];
  assign ht_ra = cmd_i.idx[HW-1:0];
  assign th_ra = tpos_q - cmd_i.idx[TW-1:0];
  assign tt_ra = cmd_i.idx[TW-1:0];

  sfc_ram #(.W(24), .D(HEAD_TAPS)) u_head_hist (
    .clk_i, .we_i(hh_we), .waddr_i(hh_wa), .wdata_i(hh_wd), .raddr_i(hh_ra), .rdata_o(hh_rd)
  );
  sfc_ram #(.W(18), .D(HEAD_TAPS)) u_head_taps (
    .clk_i, .we_i(ht_we), .waddr_i(ht_wa), .wdata_i(ht_wd), .raddr_i(ht_ra), .rdata_o(ht_rd)
  );
  sfc_ram #(.W(24), .D(TAIL_TAPS)) u_tail_hist (
    .clk_i, .we_i(th_we), .waddr_i(th_wa), .wdata_i(th_wd), .raddr_i(th_ra), .rdata_o(th_rd)
  );
  sfc_ram #(.W(18), .D(TAIL_TAPS)) u_tail_taps (
    .clk_i, .we_i(tt_we), .waddr_i(tt_wa), .wdata_i(tt_wd), .raddr_i(tt_ra), .rdata_o(tt_rd)
  );

  // MAC pipeline: read, multiply, accumulate
  logic                    rd_vld_q, sel_q, prod_vld_q;
  logic signed [41:0]      prod_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [23:0]      mac_h;
  logic signed [17:0]      mac_t;

  assign mac_h = sel_q ? th_rd : hh_rd;
  assign mac_t = sel_q ? tt_rd : ht_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
    end else begin
      rd_vld_q   <= cmd_i.mac_rd;
      prod_vld_q <= rd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q  <= cmd_i.mac_tail;
    prod_q <= mac_h * mac_t;
    if (cmd_i.smp_wr) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // filters and mix over one shared multiplier
  logic signed [23:0] x_q;
  logic signed [31:0] wet_q, lp_q, hp_q;
  logic signed [51:0] p_q, dry_q;
  logic signed [33:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [ACC_W-1:0] acc_sh;

  assign acc_sh = acc_q >>> 17;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.step)
      STEP_LP_MUL: begin
        mul_a = 34'(wet_q) - 34'(lp_q);
        mul_b = $signed({2'b00, lpc_q});
      end
      STEP_HP_MUL: begin
        mul_a = 34'(hp_q) + 34'(lp_q) - 34'(wet_q);
        mul_b = $signed({2'b00, hpc_q});
      end
      STEP_DRY_MUL: begin
        mul_a = 34'(x_q);
        mul_b = $signed({1'b0, MIX_ONE - mix_eff});
      end
      STEP_WET_MUL: begin
        mul_a = 34'(lp_q) - 34'(hp_q);
        mul_b = $signed({1'b0, mix_eff});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.smp_wr) begin
      x_q <= sample_in_i;
    end
    p_q <= mul_a * mul_b;
    if (cmd_i.step == STEP_WET) begin
      wet_q <= sat32(64'(acc_sh));
    end
    if (cmd_i.step == STEP_WET_MUL) begin
      dry_q <= p_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hpos_q <= '0;
      tpos_q <= '0;
      lp_q   <= '0;
      hp_q   <= '0;
    end else if (cmd_i.clr_state) begin
      hpos_q <= '0;
      tpos_q <= '0;
      lp_q   <= '0;
      hp_q   <= '0;
    end else begin
      if (cmd_i.adv_pos) begin
        hpos_q <= hpos_q + 1'b1;
        if (tail_on) begin
          tpos_q <= tpos_q + 1'b1;
        end
      end
      if (cmd_i.step == STEP_LP_UPD) begin
        lp_q <= sat32(64'(lp_q) + 64'(p_q >>> 16));
      end
      if (cmd_i.step == STEP_HP_UPD) begin
        hp_q <= sat32(64'(p_q >>> 16));
      end
    end
  end

  logic out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      sample_out_o <= sat24((64'(dry_q) + 64'(p_q)) >>> 16);
    end
  end

  assign out_valid_o     = out_vld_q;
  assign sts_o.mac_busy  = rd_vld_q || prod_vld_q;
  assign sts_o.out_hold  = out_vld_q && out_stall_i;
  assign sts_o.tail_on   = tail_on;
  assign sts_o.tail_len  = tlen_eff;

endmodule

`default_nettype wire

[rtl/sfc_ctrl.sv]
// ----------------------------------------------------------------------------
// sfc_ctrl
// Sequencer: memory sweep, tap loop of the shared MAC, filter and mix steps.
// ----------------------------------------------------------------------------
`default_nettype none

`include "split_fir_convolver_with_tone_filters_top_macros.svh"

module sfc_ctrl import sfc_pkg::*; #(
  parameter int unsigned HEAD_TAPS = 128,
  parameter int unsigned TAIL_TAPS = 2048
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic [1:0] operation_i,
  output logic          in_stall_o,
  output sfc_cmd_t      cmd_o,
  input  wire sfc_sts_t sts_i
);

  localparam int unsigned SWEEP_N = (HEAD_TAPS > TAIL_TAPS) ? HEAD_TAPS : TAIL_TAPS;
  localparam logic [IDX_W-1:0] SWEEP_LAST = IDX_W'(SWEEP_N - 1);
  localparam logic [IDX_W-1:0] HEAD_LAST  = IDX_W'(HEAD_TAPS - 1);

  ctl_state_e       state_q, state_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic             full_q, full_d;
  logic [IDX_W-1:0] cnt_p2;
  op_e              op;

  assign op     = op_e'(operation_i);
  assign cnt_p2 = cnt_q + IDX_W'(2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWEEP;
      cnt_q   <= '0;
      full_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      full_q  <= full_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = '0;
    full_d  = full_q;
    case (state_q)
      S_SWEEP: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == SWEEP_LAST) begin
          state_d = S_IDLE;
          cnt_d   = '0;
          full_d  = 1'b0;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          case (op)
            OP_SAMPLE: state_d = S_HEAD;
            OP_CLEAR:  state_d = S_SWEEP;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_HEAD: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == HEAD_LAST) begin
          cnt_d   = '0;
          state_d = sts_i.tail_on ? S_TAIL : S_DRAIN;
        end
      end
      S_TAIL: begin
        cnt_d = cnt_p2;
        if (cnt_p2 >= sts_i.tail_len) begin
          cnt_d   = '0;
          state_d = S_DRAIN;
        end
      end
      S_DRAIN:   if (!sts_i.mac_busy) state_d = S_WET;
      S_WET:     state_d = S_LP_MUL;
      S_LP_MUL:  state_d = S_LP_UPD;
      S_LP_UPD:  state_d = S_HP_MUL;
      S_HP_MUL:  state_d = S_HP_UPD;
      S_HP_UPD:  state_d = S_DRY_MUL;
      S_DRY_MUL: state_d = S_WET_MUL;
      S_WET_MUL: state_d = S_OUT;
      S_OUT:     if (!sts_i.out_hold) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.step = STEP_NONE;
    cmd_o.idx  = cnt_q;
    in_stall_o = 1'b1;
    case (state_q)
      S_SWEEP: begin
        cmd_o.sweep      = 1'b1;
        cmd_o.sweep_taps = full_q;
      end
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          case (op)
            OP_SAMPLE:  cmd_o.smp_wr      = 1'b1;
            OP_HEAD_WR: cmd_o.head_tap_wr = 1'b1;
            OP_TAIL_WR: cmd_o.tail_tap_wr = 1'b1;
            OP_CLEAR:   cmd_o.clr_state   = 1'b1;
            default: ;
          endcase
        end
      end
      S_HEAD: cmd_o.mac_rd = 1'b1;
      S_TAIL: begin
        cmd_o.mac_rd   = 1'b1;
        cmd_o.mac_tail = 1'b1;
      end
      S_WET: begin
        cmd_o.step    = STEP_WET;
        cmd_o.adv_pos = 1'b1;
      end
      S_LP_MUL:  cmd_o.step = STEP_LP_MUL;
      S_LP_UPD:  cmd_o.step = STEP_LP_UPD;
      S_HP_MUL:  cmd_o.step = STEP_HP_MUL;
      S_HP_UPD:  cmd_o.step = STEP_HP_UPD;
      S_DRY_MUL: cmd_o.step = STEP_DRY_MUL;
      S_WET_MUL: cmd_o.step = STEP_WET_MUL;
      S_OUT:     cmd_o.out_ld = !sts_i.out_hold;
      default: ;
    endcase
  end

  `SFC_ASSERT_IMPL(a_out_no_overwrite, cmd_o.out_ld, !sts_i.out_hold, "result overwritten")
  `SFC_ASSERT_IMPL(a_tail_needs_len, cmd_o.mac_rd && cmd_o.mac_tail, sts_i.tail_on, "tail read, tail off")
  `SFC_ASSERT_NEXT(a_sample_starts_mac, cmd_o.smp_wr, state_q == S_HEAD && cnt_q == '0, "no MAC start")

endmodule

`default_nettype wire

[rtl/split_fir_convolver_with_tone_filters_top.sv]
// ----------------------------------------------------------------------------
// split_fir_convolver_with_tone_filters_top
// Impulse-response convolver with one-pole tone filters and dry/wet mix.
// ----------------------------------------------------------------------------
// A sample transaction runs the one shared MAC over every head tap and every
// second tap below len, len being the clamped tail length (zero when the tail
// is off); it reads one history/tap pair per cycle from the ring memories, then
// filter and mix steps share a second multiplier. Tap writes and clears are
// accepted in idle; a clear then zeroes the rings in a sweep over max(HEAD_TAPS,
// TAIL_TAPS) addresses, and after reset the same sweep also zeroes the taps,
// with input stalled meanwhile. Ring sizes must be powers of two (unchecked).
// ----------------------------------------------------------------------------
`default_nettype none

module split_fir_convolver_with_tone_filters_top import sfc_pkg::*; #(
  parameter int unsigned HEAD_TAPS = 128,
  parameter int unsigned TAIL_TAPS = 2048
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         operation_i,
  input  wire logic [10:0]        tap_index_i,
  input  wire logic signed [23:0] sample_in_i,
  input  wire logic signed [17:0] tap_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [23:0]      sample_out_o,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [16:0]        cfg_data_i
);

  sfc_cmd_t cmd;
  sfc_sts_t sts;

  sfc_ctrl #(.HEAD_TAPS(HEAD_TAPS), .TAIL_TAPS(TAIL_TAPS)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .operation_i, .in_stall_o,
    .cmd_o(cmd), .sts_i(sts)
  );

  sfc_dpath #(.HEAD_TAPS(HEAD_TAPS), .TAIL_TAPS(TAIL_TAPS)) u_dpath (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .tap_index_i, .sample_in_i, .tap_value_i,
    .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .out_valid_o, .out_stall_i, .sample_out_o
  );

endmodule

`default_nettype wire

[tb/tb_split_fir_convolver_with_tone_filters_top.sv]
// ----------------------------------------------------------------------------
// Testbench for split_fir_convolver_with_tone_filters_top
// Drives tap writes, clears and samples with random idling on both channels.
// A local model of the convolver and its tone filters predicts each output
// sample, and every output transaction is compared in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_split_fir_convolver_with_tone_filters_top;
  import sfc_pkg::*;

  localparam int HEAD_N   = 128;
  localparam int TAIL_N   = 2048;
  localparam int SETTLE   = 2400;
  localparam int WD_LIMIT = 40000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         operation_i = OP_SAMPLE;
  logic [10:0]        tap_index_i = '0;
  logic signed [23:0] sample_in_i = '0;
  logic signed [17:0] tap_value_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [23:0] sample_out_o;
  logic               cfg_we_i = 1'b0;
  logic [1:0]         cfg_index_i = CFG_MIX;
  logic [16:0]        cfg_data_i = '0;

  split_fir_convolver_with_tone_filters_top dut (.*);

  // model state
  logic signed [23:0] head_hist [HEAD_N];
  logic signed [17:0] head_coef [HEAD_N];
  logic signed [23:0] tail_hist [TAIL_N];
  logic signed [17:0] tail_coef [TAIL_N];
  logic [6:0]         head_pos;
  logic [10:0]        tail_pos;
  longint             lp_level, hp_level;
  logic [16:0]        mix_reg;
  logic [15:0]        lpc_reg, hpc_reg;
  logic [11:0]        tlen_reg;

  logic signed [23:0] expected_samples [$];
  int                 mismatches = 0;
  bit                 send_idle = 1'b1;
  bit                 recv_idle = 1'b1;
  int                 quiet_cycles = 0;

  initial forever #5 clk_i = ~clk_i;

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic void clear_rings();
    foreach (head_hist[i]) head_hist[i] = '0;
    foreach (tail_hist[i]) tail_hist[i] = '0;
    head_pos = '0;
    tail_pos = '0;
    lp_level = 0;
    hp_level = 0;
  endfunction

  // returns 1 and the output sample for a sample transaction
  function automatic bit convolve(op_e op, logic [10:0] idx, logic signed [23:0] x,
                                  logic signed [17:0] tv, output logic signed [23:0] y);
    longint acc, wet, lp, hp, fw, m, len, res;
    logic [6:0]  hr;
    logic [10:0] tr;
    y = '0;
    case (op)
      OP_HEAD_WR: begin
        head_coef[idx[6:0]] = tv;
        return 1'b0;
      end
      OP_TAIL_WR: begin
        tail_coef[idx] = tv;
        return 1'b0;
      end
      OP_CLEAR: begin
        clear_rings();
        return 1'b0;
      end
      default: ;
    endcase
    acc = 0;
    head_hist[head_pos] = x;
    for (int i = 0; i < HEAD_N; i++) begin
      hr = head_pos - 7'(i);
      acc += longint'(head_hist[hr]) * longint'(head_coef[i]);
    end
    head_pos = head_pos + 7'd1;
    len = (tlen_reg > TAIL_N) ? TAIL_N : tlen_reg;
    if (len > 0) begin
      tail_hist[tail_pos] = x;
      for (int i = 0; i < len; i += 2) begin
        tr = tail_pos - 11'(i);
        acc += longint'(tail_hist[tr]) * longint'(tail_coef[i]);
      end
      tail_pos = tail_pos + 11'd1;
    end
    wet = clamp(acc >>> 17, S32_MIN, S32_MAX);
    lp = lp_level + ((longint'(lpc_reg) * (wet - lp_level)) >>> 16);
    lp = clamp(lp, S32_MIN, S32_MAX);
    lp_level = lp;
    hp = (longint'(hpc_reg) * (hp_level + lp - wet)) >>> 16;
    hp = clamp(hp, S32_MIN, S32_MAX);
    hp_level = hp;
    fw = lp - hp;
    m = (mix_reg > MIX_ONE) ? MIX_ONE : mix_reg;
    res = (longint'(x) * (65536 - m) + fw * m) >>> 16;
    y = 24'(clamp(res, S24_MIN, S24_MAX));
    return 1'b1;
  endfunction

  task automatic send_item(op_e op, logic [10:0] idx, logic signed [23:0] x,
                           logic signed [17:0] tv);
    logic signed [23:0] y;
    while (send_idle && $urandom_range(99) < 30) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    tap_index_i <= idx;
    sample_in_i <= x;
    tap_value_i <= tv;
    do @(posedge clk_i); while (in_stall_o);
    if (convolve(op, idx, x, tv, y)) expected_samples.push_back(y);
  endtask

  // all results in, then time for any sweep or tail MAC still running
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e r, logic [16:0] d);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i  <= d;
    @(posedge clk_i);
    case (r)
      CFG_MIX:  mix_reg  = d;
      CFG_LPC:  lpc_reg  = d[15:0];
      CFG_HPC:  hpc_reg  = d[15:0];
      CFG_TLEN: tlen_reg = d[11:0];
      default: ;
    endcase
  endtask

  task automatic set_all(logic [16:0] mix, logic [15:0] lpc, logic [15:0] hpc,
                         logic [11:0] tlen);
    write_reg(CFG_MIX, mix);
    write_reg(CFG_LPC, {1'b0, lpc});
    write_reg(CFG_HPC, {1'b0, hpc});
    write_reg(CFG_TLEN, {5'b0, tlen});
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_head_only();
    send_item(OP_HEAD_WR, 11'd0, '0, 18'sh1ffff);
    send_item(OP_HEAD_WR, 11'd127, '0, -18'sh20000);
    send_item(OP_HEAD_WR, 11'd2047, '0, 18'sh10000);  // wraps onto head tap 127
    send_item(OP_HEAD_WR, 11'd1, '0, 18'sh08000);
    send_item(OP_SAMPLE, '0, 24'sh7fffff, '0);
    send_item(OP_SAMPLE, '0, -24'sh800000, '0);
    send_item(OP_SAMPLE, '0, '0, '0);
    send_item(OP_SAMPLE, 11'h7ff, 24'sh7fffff, 18'sh1ffff);
    send_item(OP_SAMPLE, '0, 24'sh123456, '0);
    send_item(OP_CLEAR, '0, '0, '0);
    send_item(OP_SAMPLE, '0, -24'sh000001, '0);
    wait_drained();
  endtask

  task automatic test_tail();
    set_all(17'd65536, 16'd65535, 16'd0, 12'd16);
    send_item(OP_TAIL_WR, 11'd0, '0, 18'sh1ffff);
    send_item(OP_TAIL_WR, 11'd2, '0, -18'sh20000);
    send_item(OP_TAIL_WR, 11'd3, '0, 18'sh1ffff);     // odd tap, never summed
    send_item(OP_TAIL_WR, 11'd2046, '0, 18'sh0abcd);
    for (int i = 0; i < 4; i++) send_item(OP_SAMPLE, '0, 24'sh7fffff, '0);
    wait_drained();
    // above-range settings act as their maximum
    set_all(17'h1ffff, 16'd0, 16'd65535, 12'hfff);
    send_item(OP_SAMPLE, '0, -24'sh800000, '0);
    send_item(OP_SAMPLE, '0, 24'sh7fffff, '0);
    wait_drained();
    set_all(17'd0, 16'd65535, 16'd65535, 12'd2048);
    send_item(OP_SAMPLE, '0, 24'sh400000, '0);
    send_item(OP_CLEAR, '0, '0, '0);
    send_item(OP_SAMPLE, '0, 24'sh7fffff, '0);
    wait_drained();
  endtask

  task automatic test_random();
    int unsigned k;
    op_e op;
    for (int ph = 0; ph < 5; ph++) begin
      send_idle = (ph != 1);
      recv_idle = (ph != 1);
      if ($urandom_range(3) == 0) set_all(17'($urandom), 16'($urandom), 16'($urandom), 12'($urandom));
      else set_all(17'($urandom_range(65536)), 16'($urandom), 16'($urandom),
                   12'($urandom_range(64)));
      for (int n = 0; n < 80; n++) begin
        k = $urandom_range(99);
        op = (k < 70) ? OP_SAMPLE : (k < 84) ? OP_HEAD_WR : (k < 98) ? OP_TAIL_WR : OP_CLEAR;
        send_item(op, 11'($urandom), 24'($urandom), 18'($urandom));
      end
      wait_drained();
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output sample %0d", sample_out_o);
      end else begin
        if (sample_out_o !== expected_samples[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("sample_out: expected %0d actual %0d", expected_samples[0], sample_out_o);
        end
        void'(expected_samples.pop_front());
      end
    end
    out_stall_i <= recv_idle && ($urandom_range(99) < 30);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WD_LIMIT) begin
      $display("split_fir_convolver_with_tone_filters_top: mismatch");
      $finish;
    end
  end

  initial begin
    foreach (head_coef[i]) head_coef[i] = '0;
    foreach (tail_coef[i]) tail_coef[i] = '0;
    clear_rings();
    mix_reg  = MIX_RST;
    lpc_reg  = LPC_RST;
    hpc_reg  = HPC_RST;
    tlen_reg = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (SETTLE) @(posedge clk_i);
    test_head_only();
    test_tail();
    test_random();
    if (mismatches == 0) $display("split_fir_convolver_with_tone_filters_top: match");
    else $display("split_fir_convolver_with_tone_filters_top: mismatch");
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
+incdir+rtl
rtl/sfc_pkg.sv
rtl/sfc_ram.sv
rtl/sfc_dpath.sv
rtl/sfc_ctrl.sv
rtl/split_fir_convolver_with_tone_filters_top.sv
tb/tb_split_fir_convolver_with_tone_filters_top.sv
